[hdl/websocket_masked_frame_encoder_macros.svh]
// assertion macros for the masked frame encoder checker
// needs clk_i and rst_ni in the scope of use
`ifndef WEBSOCKET_MASKED_FRAME_ENCODER_MACROS_SVH
`define WEBSOCKET_MASKED_FRAME_ENCODER_MACROS_SVH

// same-cycle implication
`define WSFE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wsfe same-cycle check failed");

// next-cycle implication
`define WSFE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wsfe next-cycle check failed");

`endif

[hdl/wsfe_pkg.sv]
// shared types, constants and helpers of the masked frame encoder
// no dependencies
package wsfe_pkg;

  localparam int unsigned MaxRun     = 9;
  localparam int unsigned RunCntW    = $clog2(MaxRun + 1);
  localparam int unsigned ShortLimit = 125;

  localparam logic [7:0]  ExtLenByte  = 8'hFE;
  localparam logic [7:0]  MaskBit     = 8'h80;
  localparam logic [31:0] KeyReset    = 32'h1234_5678;
  localparam logic [7:0]  HdrReset    = 8'h81;

  typedef logic [7:0] wire_byte_t;
  typedef logic [RunCntW-1:0] run_cnt_t;

  typedef enum logic {
    REG_MASK_KEY = 1'b0,
    REG_HDR_BYTE = 1'b1
  } cfg_reg_e;

  // run handed from the builder to the output buffer
  typedef struct packed {
    logic     load;
    run_cnt_t count;
    logic     fend;
  } run_t;

  // key byte for a mask phase, top byte first
  function automatic wire_byte_t key_byte(input logic [31:0] key, input logic [1:0] phase);
    wire_byte_t kb;
    case (phase)
      2'd0:    kb = key[31:24];
      2'd1:    kb = key[23:16];
      2'd2:    kb = key[15:8];
      default: kb = key[7:0];
    endcase
    return kb;
  endfunction

endpackage

[hdl/wsfe_run_build.sv]
// frame state, config registers and run builder of the masked frame encoder
// depends on wsfe_pkg
module wsfe_run_build
  import wsfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         accept_i,
  input  logic         start_i,
  input  logic [15:0]  len_i,
  input  logic         carries_i,
  input  wire_byte_t   data_i,
  output run_t         run_o,
  output wire_byte_t   bytes_o [MaxRun]
);

  logic [31:0] key_q;
  wire_byte_t  hdr_q;
  logic [1:0]  phase_q, phase_d;
  logic [15:0] left_q, left_d;
  logic        in_frame_q, in_frame_d;

  run_cnt_t    count;
  logic        fend;
  logic        is_short;
  wire_byte_t  masked_first;
  wire_byte_t  masked_cont;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KeyReset;
      hdr_q <= HdrReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MASK_KEY: key_q <= cfg_data_i;
        REG_HDR_BYTE: hdr_q <= cfg_data_i[7:0];
        default:      ;
      endcase
    end
  end

  assign is_short     = ({16'd0, len_i} <= 32'(ShortLimit));
  assign masked_first = data_i ^ key_q[31:24];
  assign masked_cont  = data_i ^ key_byte(key_q, phase_q);

  always_comb begin
    for (int i = 0; i < MaxRun; i++) begin
      bytes_o[i] = '0;
    end
    count      = '0;
    fend       = 1'b0;
    phase_d    = phase_q;
    left_d     = left_q;
    in_frame_d = in_frame_q;
    if (start_i) begin
      bytes_o[0] = hdr_q;
      if (is_short) begin
        bytes_o[1] = MaskBit | {1'b0, len_i[6:0]};
        bytes_o[2] = key_q[31:24];
        bytes_o[3] = key_q[23:16];
        bytes_o[4] = key_q[15:8];
        bytes_o[5] = key_q[7:0];
        bytes_o[6] = masked_first;
        count      = run_cnt_t'(6);
      end else begin
        bytes_o[1] = ExtLenByte;
        bytes_o[2] = len_i[15:8];
        bytes_o[3] = len_i[7:0];
        bytes_o[4] = key_q[31:24];
        bytes_o[5] = key_q[23:16];
        bytes_o[6] = key_q[15:8];
        bytes_o[7] = key_q[7:0];
        bytes_o[8] = masked_first;
        count      = run_cnt_t'(8);
      end
      if (len_i == 16'd0) begin
        // empty frame ends on the last key byte
        fend       = 1'b1;
        phase_d    = 2'd0;
        left_d     = 16'd0;
        in_frame_d = 1'b0;
      end else if (carries_i) begin
        count      = count + run_cnt_t'(1);
        fend       = (len_i == 16'd1);
        phase_d    = 2'd1;
        left_d     = len_i - 16'd1;
        in_frame_d = (len_i != 16'd1);
      end else begin
        phase_d    = 2'd0;
        left_d     = len_i;
        in_frame_d = 1'b1;
      end
    end else if (in_frame_q && carries_i) begin
      bytes_o[0] = masked_cont;
      count      = run_cnt_t'(1);
      fend       = (left_q == 16'd1);
      phase_d    = phase_q + 2'd1;
      left_d     = left_q - 16'd1;
      in_frame_d = (left_q != 16'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= 2'd0;
      left_q     <= 16'd0;
      in_frame_q <= 1'b0;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      left_q     <= left_d;
      in_frame_q <= in_frame_d;
    end
  end

  assign run_o.load  = accept_i && (count != '0);
  assign run_o.count = count;
  assign run_o.fend  = fend;

endmodule

[hdl/wsfe_run_buf.sv]
// run buffer and output register of the masked frame encoder
// depends on wsfe_pkg
module wsfe_run_buf
  import wsfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  run_t        run_i,
  input  wire_byte_t  bytes_i [MaxRun],
  output logic        free_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output wire_byte_t  m_data_o,
  output logic        m_last_o,
  output logic        m_fend_o
);

  wire_byte_t buf_q [MaxRun];
  wire_byte_t buf_d [MaxRun];
  run_cnt_t   left_q, left_d;
  logic       fend_q;
  logic       valid_q;
  wire_byte_t data_q;
  logic       last_q;
  logic       ofend_q;
  logic       out_free;
  logic       move;
  logic       final_move;

  assign out_free   = !valid_q || m_ready_i;
  assign move       = (left_q != '0) && out_free;
  assign final_move = move && (left_q == run_cnt_t'(1));
  assign free_o     = (left_q == '0) || final_move;

  always_comb begin
    buf_d  = buf_q;
    left_d = left_q;
    if (run_i.load) begin
      buf_d  = bytes_i;
      left_d = run_i.count;
    end else if (move) begin
      for (int i = 0; i < MaxRun - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      buf_d[MaxRun-1] = '0;
      left_d          = left_q - run_cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (run_i.load) begin
      fend_q <= run_i.fend;
    end
    if (move) begin
      data_q  <= buf_q[0];
      last_q  <= (left_q == run_cnt_t'(1));
      ofend_q <= (left_q == run_cnt_t'(1)) && fend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      left_q <= left_d;
      if (move) begin
        valid_q <= 1'b1;
      end else if (m_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_last_o  = last_q;
  assign m_fend_o  = ofend_q;

endmodule

[hdl/websocket_masked_frame_encoder.sv]
// top level of the masked websocket client frame encoder
// depends on wsfe_pkg, wsfe_run_build and wsfe_run_buf
//
//  port group   dir  contents
//  s_axis       in   start / length / payload byte items
//  m_axis       out  frame bytes: header, key, masked payload
//  cfg          in   register writes: mask key, first header byte
//
// a payload item yields one output byte; a start item 6 or 8 (one more if it
// carries the first payload byte). a taken item is registered into the run
// buffer, which the one-byte output register drains byte by byte. reset
// clears frame state, loads the key and header defaults and empties both
// buffers. a stall on m_axis holds the output register and the run buffer;
// s_axis stays ready while the buffer can take the next run.
module websocket_masked_frame_encoder
  import wsfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // frame_length[15:0], data_byte[23:16]
  input  logic [1:0]  s_axis_tuser,   // frame_start[0], carries_byte[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // frame_end[0]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  run_t       run;
  wire_byte_t run_bytes [MaxRun];
  logic       buf_free;
  logic       accept;

  assign s_axis_tready = buf_free;
  assign accept        = s_axis_tvalid && buf_free;

  wsfe_run_build u_build (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .start_i    (s_axis_tuser[0]),
    .len_i      (s_axis_tdata[15:0]),
    .carries_i  (s_axis_tuser[1]),
    .data_i     (s_axis_tdata[23:16]),
    .run_o      (run),
    .bytes_o    (run_bytes)
  );

  wsfe_run_buf u_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .run_i     (run),
    .bytes_i   (run_bytes),
    .free_o    (buf_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast),
    .m_fend_o  (m_axis_tuser)
  );

endmodule

[hdl/wsfe_checker.sv]
// port-level checks of the masked frame encoder, bound to the top level
// depends on websocket_masked_frame_encoder_macros.svh
`include "websocket_masked_frame_encoder_macros.svh"

module wsfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser
);

  // frame end always closes the run
  `WSFE_ASSERT_NOW(fend_is_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

  // back-pressure on the input only while bytes are pending for the output
  `WSFE_ASSERT_NEXT(stall_has_output, !s_axis_tready, m_axis_tvalid)

  // stalled output transaction holds
  `WSFE_ASSERT_NEXT(out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

endmodule

bind websocket_masked_frame_encoder wsfe_checker u_wsfe_checker (.*);

[verif/tb.sv]
// testbench for the masked websocket frame encoder: directed table, then random frames
// in several key and header settings, checked against a cycle-free byte predictor
// depends on wsfe_pkg and websocket_masked_frame_encoder
`timescale 1ns / 100ps

module tb;
  import wsfe_pkg::*;

  localparam int unsigned SettleCycles = 12;
  localparam int unsigned RandomItems  = 300;
  localparam int unsigned NumPhases    = 5;

  typedef struct packed {
    logic [7:0] wb;
    logic       run_last;
    logic       frm_end;
  } wire_exp_t;

  // directed row: typed rows carry their wire bytes left-aligned in exp_bytes
  typedef struct packed {
    logic        start;
    logic [15:0] len;
    logic        carries;
    logic [7:0]  data;
    logic        typed;
    logic [3:0]  ntyped;
    logic [71:0] exp_bytes;
    logic        fe_last;
  } dir_row_t;

  localparam int unsigned NumRows = 20;
  localparam dir_row_t DirTab [NumRows] = '{
    // empty frame, byte ignored, frame ends on last key byte
    '{1'b1, 16'd0,     1'b1, 8'hFF, 1'b1, 4'd6, 72'h81_80_12_34_56_78_00_00_00, 1'b1},
    // longest short form, header only
    '{1'b1, 16'd125,   1'b1 & 1'b0, 8'h00, 1'b1, 4'd6, 72'h81_FD_12_34_56_78_00_00_00, 1'b0},
    // shortest long form abandons the open frame, first byte in the same run
    '{1'b1, 16'd126,   1'b1, 8'h00, 1'b1, 4'd9, 72'h81_FE_00_7E_12_34_56_78_12, 1'b0},
    '{1'b0, 16'd0,     1'b1, 8'hFF, 1'b1, 4'd1, 72'hCB_00_00_00_00_00_00_00_00, 1'b0},
    // no byte, no start: nothing
    '{1'b0, 16'hFFFF,  1'b0, 8'hFF, 1'b1, 4'd0, 72'h0, 1'b0},
    '{1'b1, 16'hFFFF,  1'b1, 8'hAA, 1'b1, 4'd9, 72'h81_FE_FF_FF_12_34_56_78_B8, 1'b0},
    '{1'b0, 16'hA5A5,  1'b1, 8'h55, 1'b0, 4'd0, 72'h0, 1'b0},
    '{1'b0, 16'd0,     1'b1, 8'h00, 1'b0, 4'd0, 72'h0, 1'b0},
    '{1'b0, 16'd0,     1'b1, 8'h7F, 1'b0, 4'd0, 72'h0, 1'b0},
    '{1'b0, 16'd0,     1'b1, 8'h80, 1'b0, 4'd0, 72'h0, 1'b0},
    '{1'b1, 16'd1,     1'b0, 8'h00, 1'b1, 4'd6, 72'h81_81_12_34_56_78_00_00_00, 1'b0},
    '{1'b0, 16'd0,     1'b1, 8'h3C, 1'b0, 4'd0, 72'h0, 1'b0},
    // payload with no frame open: nothing
    '{1'b0, 16'd0,     1'b1, 8'h99, 1'b1, 4'd0, 72'h0, 1'b0},
    '{1'b1, 16'd3,     1'b1, 8'h01, 1'b0, 4'd0, 72'h0, 1'b0},
    '{1'b0, 16'd0,     1'b1, 8'h02, 1'b0, 4'd0, 72'h0, 1'b0},
    '{1'b0, 16'd0,     1'b1, 8'h03, 1'b0, 4'd0, 72'h0, 1'b0},
    '{1'b1, 16'd0,     1'b0, 8'h00, 1'b1, 4'd6, 72'h81_80_12_34_56_78_00_00_00, 1'b1},
    '{1'b1, 16'd127,   1'b0, 8'h00, 1'b0, 4'd0, 72'h0, 1'b0},
    '{1'b0, 16'd0,     1'b0, 8'h5A, 1'b1, 4'd0, 72'h0, 1'b0},
    '{1'b0, 16'd0,     1'b1, 8'hEE, 1'b0, 4'd0, 72'h0, 1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // frame_length[15:0], data_byte[23:16]
  logic [1:0]  s_axis_tuser = '0;  // frame_start[0], carries_byte[1]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // out_byte[7:0]
  logic        m_axis_tlast;
  logic        m_axis_tuser;       // frame_end[0]
  logic        cfg_we_i = 1'b0;
  cfg_reg_e    cfg_idx_i = REG_MASK_KEY;
  logic [31:0] cfg_data_i = '0;

  // predictor state and register copies
  logic [31:0] key_r = KeyReset;
  logic [7:0]  hdr_r = HdrReset;
  logic [1:0]  mask_ph = '0;
  logic [15:0] left_cnt = '0;
  logic        open_frm = 1'b0;

  wire_exp_t   pred_run [$];
  wire_exp_t   wire_q [$];
  wire_exp_t   seen;
  int          err_cnt = 0;
  int          taken = 0;
  logic        steady = 1'b0;

  websocket_masked_frame_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("FAIL websocket_masked_frame_encoder");
    $finish;
  end

  function automatic int idle_gap();
    return steady ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic wire_exp_t masked_payload(input logic [7:0] db);
    wire_exp_t r;
    r.wb = db ^ key_r[(3 - mask_ph) * 8 +: 8];
    mask_ph = mask_ph + 2'd1;
    left_cnt = left_cnt - 16'd1;
    if (left_cnt == 16'd0) open_frm = 1'b0;
    r.run_last = 1'b0;
    r.frm_end = !open_frm;
    return r;
  endfunction

  // wire bytes caused by one input transaction, left in pred_run
  function automatic void predict_frame(input logic st, input logic [15:0] ln,
                                        input logic cb, input logic [7:0] db);
    int p;
    pred_run.delete();
    if (st) begin
      pred_run.push_back('{hdr_r, 1'b0, 1'b0});
      if (ln <= ShortLimit) begin
        pred_run.push_back('{MaskBit | {1'b0, ln[6:0]}, 1'b0, 1'b0});
      end else begin
        pred_run.push_back('{ExtLenByte, 1'b0, 1'b0});
        pred_run.push_back('{ln[15:8], 1'b0, 1'b0});
        pred_run.push_back('{ln[7:0], 1'b0, 1'b0});
      end
      for (p = 0; p < 4; p++) pred_run.push_back('{key_r[(3 - p) * 8 +: 8], 1'b0, 1'b0});
      mask_ph = 2'd0;
      left_cnt = ln;
      open_frm = (ln != 16'd0);
      if (!open_frm) pred_run[pred_run.size() - 1].frm_end = 1'b1;
      else if (cb) pred_run.push_back(masked_payload(db));
    end else if (open_frm && cb) begin
      pred_run.push_back(masked_payload(db));
    end
    if (pred_run.size() > 0) pred_run[pred_run.size() - 1].run_last = 1'b1;
  endfunction

  task automatic drive_item(input logic st, input logic [15:0] ln,
                            input logic cb, input logic [7:0] db);
    int   gap;
    logic rdy;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {db, ln};
    s_axis_tuser  <= {cb, st};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    predict_frame(st, ln, cb, db);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_MASK_KEY: key_r = val;
      REG_HDR_BYTE: hdr_r = val[7:0];
      default: ;
    endcase
  endtask

  task automatic settle_outputs();
    s_axis_tvalid <= 1'b0;
    while (wire_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // mostly well-formed frames; long frames get abandoned by a new start
  task automatic random_item();
    logic        st;
    logic        cb;
    logic [15:0] ln;
    logic [7:0]  db;
    int          sel;
    if ($urandom_range(0, 49) == 0) steady = !steady;
    ln = 16'($urandom_range(0, 65535));
    db = 8'($urandom_range(0, 255));
    cb = 1'b1;
    st = 1'b0;
    if (!open_frm && $urandom_range(0, 4) == 0) begin
      cb = 1'($urandom_range(0, 1));
    end else if (!open_frm || (left_cnt > 16'd140 && $urandom_range(0, 9) == 0)
                 || $urandom_range(0, 39) == 0) begin
      st = 1'b1;
      sel = $urandom_range(0, 9);
      if (sel < 7) ln = 16'($urandom_range(0, 20));
      else if (sel < 8) ln = 16'($urandom_range(121, 130));
      cb = ($urandom_range(0, 3) != 0);
    end else if ($urandom_range(0, 9) == 0) begin
      cb = 1'b0;
    end
    drive_item(st, ln, cb, db);
    foreach (pred_run[i]) wire_q.push_back(pred_run[i]);
    taken++;
  endtask

  // sink side: random stall before each output transaction
  initial begin
    int   gap;
    logic took;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = idle_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        took = m_axis_tvalid;
        @(posedge clk_i);
      end while (!took);
    end
  end

  // values are stable at the falling edge and hold through the next rising one
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (wire_q.size() == 0) begin
        $error("unexpected wire byte %02h", m_axis_tdata);
        err_cnt++;
      end else begin
        seen = wire_q.pop_front();
        if (m_axis_tdata !== seen.wb) begin
          $error("out_byte: expected %02h, got %02h", seen.wb, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tlast !== seen.run_last) begin
          $error("last_of_run: expected %0b, got %0b", seen.run_last, m_axis_tlast);
          err_cnt++;
        end
        if (m_axis_tuser !== seen.frm_end) begin
          $error("frame_end: expected %0b, got %0b", seen.frm_end, m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int k;
    int ph;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTab[i]) begin
      drive_item(DirTab[i].start, DirTab[i].len, DirTab[i].carries, DirTab[i].data);
      if (DirTab[i].typed) begin
        for (k = 0; k < DirTab[i].ntyped; k++) begin
          wire_q.push_back('{DirTab[i].exp_bytes[71 - 8 * k -: 8],
                             k == DirTab[i].ntyped - 1,
                             DirTab[i].fe_last && (k == DirTab[i].ntyped - 1)});
        end
      end else begin
        foreach (pred_run[j]) wire_q.push_back(pred_run[j]);
      end
    end

    // frames may stay open across a setting change, so new keys hit live frames
    for (ph = 0; ph < NumPhases; ph++) begin
      settle_outputs();
      case (ph)
        0: begin
          write_reg(REG_MASK_KEY, 32'h0000_0000);
          write_reg(REG_HDR_BYTE, 32'h0000_0000);
        end
        1: begin
          write_reg(REG_MASK_KEY, 32'hFFFF_FFFF);
          write_reg(REG_HDR_BYTE, 32'h0000_00FF);
        end
        2: begin
          write_reg(REG_MASK_KEY, $urandom);
          write_reg(REG_HDR_BYTE, 32'h0000_0082);
        end
        3: begin
          write_reg(REG_MASK_KEY, $urandom);
          write_reg(REG_HDR_BYTE, $urandom_range(0, 255));
        end
        default: begin
          write_reg(REG_MASK_KEY, $urandom);
          write_reg(REG_HDR_BYTE, {24'd0, HdrReset});
        end
      endcase
      cfg_we_i <= 1'b0;
      while (taken < (ph + 1) * RandomItems / NumPhases) random_item();
    end

    settle_outputs();
    if (wire_q.size() != 0) begin
      $error("%0d wire bytes never arrived", wire_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("PASS websocket_masked_frame_encoder");
    end else begin
      $display("FAIL websocket_masked_frame_encoder");
    end
    $finish;
  end

endmodule
